@@ rtl/htlp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htlp_pkg
// Shared types and constants of the handle table with linear probing.
// ----------------------------------------------------------------------------
package htlp_pkg;

    localparam int TABLE_SLOTS_DEF = 256;
    localparam int ID_BITS_DEF     = 32;

    localparam int OP_W     = 2;
    localparam int EID_W    = 32;
    localparam int SIDX_W   = 8;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 56;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_NOT_FOUND = 2'd1,
        STS_FULL      = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HOME,
        ST_PROBE,
        ST_DENSE_RD,
        ST_DENSE_WAIT,
        ST_ERASE,
        ST_DONE
    } state_t;

    // what a probe is looking for
    typedef enum logic [1:0] {
        PM_EMPTY,
        PM_ID,
        PM_MOVE
    } mode_t;

endpackage
`default_nettype wire

@@ rtl/handle_table_linear_probe_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// handle_table_linear_probe_unit
// Id allocator with an open-addressing hash table (linear probing) that maps
// live ids to dense storage slots; add, swap-remove, lookup and clear.
// ----------------------------------------------------------------------------
// channel   dir  tdata                                         tuser
// s_axis    in   entity_id[31:0]                               operation[1:0]
// m_axis    out  status, result_id, storage_index, moved,      -
//                moved_from_index (from bit 0 up)
//
// A transaction runs a home pass and a probe pass (more for a moving remove).
// The home pass is skipped for a power-of-two TABLE_SLOTS; else it reduces the
// id to its home slot remainder, four id bits per cycle. The probe reads the
// hash RAM one slot per cycle, up to TABLE_SLOTS slots. A remove that moves
// an entry also runs ST_DENSE_RD, ST_DENSE_WAIT, a second pass and ST_ERASE.
// Reset and clear run a clearing pass over every hash RAM slot;
// no input is taken meanwhile. A stalled result holds the block in ST_DONE.
// ----------------------------------------------------------------------------
module handle_table_linear_probe_unit
    import htlp_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
    parameter int ID_BITS     = ID_BITS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [S_DATA_W-1:0] s_axis_tdata,  // entity_id
    input  wire logic [OP_W-1:0]     s_axis_tuser,  // operation
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // status[1:0], result_id[33:2], storage_index[41:34], moved[42],
    // moved_from_index[50:43], zero pad
    output logic [M_DATA_W-1:0]      m_axis_tdata
);

    localparam int  IDX_W    = $clog2(TABLE_SLOTS);
    localparam int  CNT_W    = $clog2(TABLE_SLOTS + 1);
    localparam int  HM_CH    = 4;
    localparam int  HM_STEPS = (ID_BITS + HM_CH - 1) / HM_CH;
    localparam int  WT_N     = (HM_STEPS + 1) * HM_CH;
    localparam int  SW       = IDX_W + 3;
    localparam int  HCNT_W   = $clog2(HM_STEPS + 1);
    localparam int  HW       = IDX_W + ID_BITS;
    localparam bit  POW2     = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;

    // weight of each id bit: 2^k mod TABLE_SLOTS
    function automatic logic [WT_N*IDX_W-1:0] hm_weights();
        logic [WT_N*IDX_W-1:0] w;
        longint unsigned       v;
        w = '0;
        v = 1;
        for (int k = 0; k < WT_N; k++) begin
            w[k*IDX_W +: IDX_W] = IDX_W'(v % TABLE_SLOTS);
            v = (v * 2) % TABLE_SLOTS;
        end
        return w;
    endfunction

    localparam logic [WT_N*IDX_W-1:0] HM_WT = hm_weights();

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    mode_t  mode_reg, mode_next;

    logic [ID_BITS-1:0] key_reg, key_next;
    logic [CNT_W-1:0]   live_reg, live_next;
    logic [ID_BITS-1:0] nid_reg, nid_next;
    logic [CNT_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic               clr_op_reg, clr_op_next;
    logic [ID_BITS-1:0] hm_val_reg, hm_val_next;
    logic [IDX_W-1:0]   hm_rem_reg, hm_rem_next;
    logic [HCNT_W-1:0]  hm_cnt_reg, hm_cnt_next;
    logic [IDX_W-1:0]   pb_pos_reg, pb_pos_next;
    logic [CNT_W-1:0]   pb_cnt_reg, pb_cnt_next;
    logic               chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]   chk_pos_reg, chk_pos_next;
    logic               chk_last_reg, chk_last_next;
    logic [IDX_W-1:0]   d_pos_reg, d_pos_next;
    logic [IDX_W-1:0]   s_idx_reg, s_idx_next;
    status_t            res_status_reg, res_status_next;
    logic [EID_W-1:0]   res_rid_reg, res_rid_next;
    logic [SIDX_W-1:0]  res_sidx_reg, res_sidx_next;
    logic               res_moved_reg, res_moved_next;
    logic [SIDX_W-1:0]  res_from_reg, res_from_next;
    logic               m_vld_reg, m_vld_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;

    logic               h_we;
    logic [IDX_W-1:0]   h_waddr, h_raddr;
    logic [HW-1:0]      h_wdata, h_rdata;
    logic               d_we;
    logic [IDX_W-1:0]   d_waddr;
    logic [ID_BITS-1:0] d_wdata, d_rdata;

    logic               acc;
    op_t                op_in;
    logic [ID_BITS-1:0] in_key, hs_src, hs_val, nid_inc;
    logic [ID_BITS-1:0] h_rid;
    logic [IDX_W-1:0]   h_ridx;
    logic [CNT_W-1:0]   last_cnt;
    logic [IDX_W-1:0]   last_idx;
    logic               pb_issue, pb_match, pb_hit, pb_miss;
    logic               found_live, s_is_last, hm_done, out_free, clr_end;
    logic [SW-1:0]      hm_sum, hm_r4, hm_r2, hm_red;

    htlp_ram #(.WIDTH(HW), .DEPTH(TABLE_SLOTS)) u_hash_ram (
        .clk   (aclk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (h_wdata),
        .raddr (h_raddr),
        .rdata (h_rdata)
    );

    htlp_ram #(.WIDTH(ID_BITS), .DEPTH(TABLE_SLOTS)) u_dense_ram (
        .clk   (aclk),
        .we    (d_we),
        .waddr (d_waddr),
        .wdata (d_wdata),
        .raddr (last_idx),
        .rdata (d_rdata)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign acc           = s_axis_tvalid & s_axis_tready;
    assign op_in         = op_t'(s_axis_tuser);
    assign in_key        = ID_BITS'(s_axis_tdata);
    assign h_rid         = h_rdata[ID_BITS-1:0];
    assign h_ridx        = h_rdata[HW-1:ID_BITS];
    assign last_cnt      = live_reg - CNT_W'(1);
    assign last_idx      = IDX_W'(last_cnt);
    assign nid_inc       = nid_reg + ID_BITS'(1);
    assign hs_src        = (state_reg == ST_DENSE_WAIT) ? d_rdata :
                           (op_in == OP_ADD) ? nid_reg : in_key;
    assign hs_val        = hs_src - ID_BITS'(1);
    assign hm_done       = (hm_cnt_reg == HCNT_W'(HM_STEPS));
    assign pb_issue      = (pb_cnt_reg != CNT_W'(TABLE_SLOTS));
    assign found_live    = (CNT_W'(h_ridx) < live_reg);
    assign s_is_last     = (CNT_W'(h_ridx) == last_cnt);
    assign out_free      = !m_vld_reg || m_axis_tready;
    assign clr_end       = (clr_cnt_reg == CNT_W'(TABLE_SLOTS - 1));

    // home slot: weighted sum of four id bits, folded back below TABLE_SLOTS
    always_comb begin
        hm_sum = SW'(hm_rem_reg);
        for (int j = 0; j < HM_CH; j++) begin
            if (hm_val_reg[j]) begin
                hm_sum = hm_sum +
                         SW'(HM_WT[(int'(hm_cnt_reg) * HM_CH + j) * IDX_W +: IDX_W]);
            end
        end
        hm_r4  = (hm_sum >= SW'(4 * TABLE_SLOTS)) ? hm_sum - SW'(4 * TABLE_SLOTS) : hm_sum;
        hm_r2  = (hm_r4 >= SW'(2 * TABLE_SLOTS)) ? hm_r4 - SW'(2 * TABLE_SLOTS) : hm_r4;
        hm_red = (hm_r2 >= SW'(TABLE_SLOTS)) ? hm_r2 - SW'(TABLE_SLOTS) : hm_r2;
    end

    always_comb begin
        case (mode_reg)
            PM_EMPTY: pb_match = (h_rid == '0);
            PM_ID:    pb_match = (h_rid == key_reg);
            PM_MOVE:  pb_match = (h_rid == key_reg) && (h_ridx == last_idx);
            default:  pb_match = 1'b0;
        endcase
    end

    assign pb_hit  = chk_vld_reg && pb_match;
    assign pb_miss = chk_vld_reg && !pb_match && chk_last_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_end) begin
                    state_next = clr_op_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (acc) begin
                    case (op_in)
                        OP_ADD: begin
                            if (live_reg == CNT_W'(TABLE_SLOTS)) begin
                                state_next = ST_DONE;
                            end else begin
                                state_next = POW2 ? ST_PROBE : ST_HOME;
                            end
                        end
                        OP_REMOVE, OP_LOOKUP: begin
                            if (in_key == '0) begin
                                state_next = ST_DONE;
                            end else begin
                                state_next = POW2 ? ST_PROBE : ST_HOME;
                            end
                        end
                        OP_CLEAR: state_next = ST_CLEAR;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_HOME: begin
                if (hm_done) begin
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (pb_hit) begin
                    case (mode_reg)
                        PM_ID: begin
                            if (!found_live || op_reg == OP_LOOKUP || s_is_last) begin
                                state_next = ST_DONE;
                            end else begin
                                state_next = ST_DENSE_RD;
                            end
                        end
                        PM_MOVE: state_next = ST_ERASE;
                        default: state_next = ST_DONE;
                    endcase
                end else if (pb_miss) begin
                    state_next = (mode_reg == PM_MOVE) ? ST_ERASE : ST_DONE;
                end
            end
            ST_DENSE_RD:   state_next = ST_DENSE_WAIT;
            ST_DENSE_WAIT: state_next = POW2 ? ST_PROBE : ST_HOME;
            ST_ERASE:      state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // datapath and memory control
    always_comb begin
        op_next         = op_reg;
        mode_next       = mode_reg;
        key_next        = key_reg;
        live_next       = live_reg;
        nid_next        = nid_reg;
        clr_cnt_next    = clr_cnt_reg;
        clr_op_next     = clr_op_reg;
        hm_val_next     = hm_val_reg;
        hm_rem_next     = hm_rem_reg;
        hm_cnt_next     = hm_cnt_reg;
        pb_pos_next     = pb_pos_reg;
        pb_cnt_next     = pb_cnt_reg;
        chk_vld_next    = 1'b0;
        chk_pos_next    = chk_pos_reg;
        chk_last_next   = chk_last_reg;
        d_pos_next      = d_pos_reg;
        s_idx_next      = s_idx_reg;
        res_status_next = res_status_reg;
        res_rid_next    = res_rid_reg;
        res_sidx_next   = res_sidx_reg;
        res_moved_next  = res_moved_reg;
        res_from_next   = res_from_reg;
        m_data_next     = m_data_reg;
        m_vld_next      = m_vld_reg && !m_axis_tready;
        h_we            = 1'b0;
        h_waddr         = chk_pos_reg;
        h_wdata         = '0;
        h_raddr         = pb_pos_reg;
        d_we            = 1'b0;
        d_waddr         = s_idx_reg;
        d_wdata         = key_reg;

        // probe start, shared by transaction entry and the move search
        if ((state_reg == ST_IDLE && acc) || state_reg == ST_DENSE_WAIT) begin
            hm_val_next  = hs_val;
            hm_rem_next  = '0;
            hm_cnt_next  = '0;
            pb_pos_next  = IDX_W'(hs_val);
            pb_cnt_next  = '0;
        end

        case (state_reg)
            ST_CLEAR: begin
                h_we         = 1'b1;
                h_waddr      = IDX_W'(clr_cnt_reg);
                clr_cnt_next = clr_cnt_reg + CNT_W'(1);
                if (clr_end) begin
                    clr_op_next = 1'b0;
                end
            end
            ST_IDLE: begin
                if (acc) begin
                    op_next         = op_in;
                    key_next        = in_key;
                    mode_next       = (op_in == OP_ADD) ? PM_EMPTY : PM_ID;
                    res_status_next = STS_OK;
                    res_rid_next    = EID_W'(in_key);
                    res_sidx_next   = '0;
                    res_moved_next  = 1'b0;
                    res_from_next   = '0;
                    case (op_in)
                        OP_ADD: begin
                            res_rid_next = '0;
                            if (live_reg == CNT_W'(TABLE_SLOTS)) begin
                                res_status_next = STS_FULL;
                            end
                        end
                        OP_REMOVE, OP_LOOKUP: begin
                            if (in_key == '0) begin
                                res_status_next = STS_NOT_FOUND;
                            end
                        end
                        OP_CLEAR: begin
                            live_next    = '0;
                            nid_next     = ID_BITS'(1);
                            clr_cnt_next = '0;
                            clr_op_next  = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            ST_HOME: begin
                if (hm_done) begin
                    pb_pos_next = hm_rem_reg;
                end else begin
                    hm_rem_next = IDX_W'(hm_red);
                    hm_val_next = hm_val_reg >> HM_CH;
                    hm_cnt_next = hm_cnt_reg + HCNT_W'(1);
                end
            end
            ST_PROBE: begin
                if (pb_issue) begin
                    pb_pos_next = (pb_pos_reg == IDX_W'(TABLE_SLOTS - 1)) ?
                                  '0 : pb_pos_reg + IDX_W'(1);
                    pb_cnt_next = pb_cnt_reg + CNT_W'(1);
                end
                chk_vld_next  = pb_issue;
                chk_pos_next  = pb_pos_reg;
                chk_last_next = (pb_cnt_reg == CNT_W'(TABLE_SLOTS - 1));
                if (pb_hit || pb_miss) begin
                    chk_vld_next = 1'b0;
                    pb_cnt_next  = CNT_W'(TABLE_SLOTS);
                end
                if (pb_hit) begin
                    case (mode_reg)
                        PM_EMPTY: begin
                            h_we          = 1'b1;
                            h_wdata       = {IDX_W'(live_reg), nid_reg};
                            d_we          = 1'b1;
                            d_waddr       = IDX_W'(live_reg);
                            d_wdata       = nid_reg;
                            res_rid_next  = EID_W'(nid_reg);
                            res_sidx_next = SIDX_W'(live_reg);
                            live_next     = live_reg + CNT_W'(1);
                            nid_next      = (nid_inc == '0) ? ID_BITS'(1) : nid_inc;
                        end
                        PM_ID: begin
                            if (!found_live) begin
                                res_status_next = STS_NOT_FOUND;
                            end else begin
                                res_sidx_next = SIDX_W'(h_ridx);
                                s_idx_next    = h_ridx;
                                d_pos_next    = chk_pos_reg;
                                if (op_reg == OP_REMOVE && s_is_last) begin
                                    h_we      = 1'b1;
                                    live_next = last_cnt;
                                end
                            end
                        end
                        PM_MOVE: begin
                            h_we    = 1'b1;
                            h_wdata = {s_idx_reg, key_reg};
                            d_we    = 1'b1;
                        end
                        default: ;
                    endcase
                end else if (pb_miss) begin
                    case (mode_reg)
                        PM_EMPTY: res_status_next = STS_FULL;
                        PM_ID:    res_status_next = STS_NOT_FOUND;
                        PM_MOVE:  d_we = 1'b1;
                        default: ;
                    endcase
                end
            end
            ST_DENSE_WAIT: begin
                key_next  = d_rdata;
                mode_next = PM_MOVE;
            end
            ST_ERASE: begin
                h_we           = 1'b1;
                h_waddr        = d_pos_reg;
                live_next      = last_cnt;
                res_moved_next = 1'b1;
                res_from_next  = SIDX_W'(last_idx);
            end
            ST_DONE: begin
                if (out_free) begin
                    m_vld_next  = 1'b1;
                    m_data_next = {5'd0, res_from_reg, res_moved_reg, res_sidx_reg,
                                   res_rid_reg, res_status_reg};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            live_reg    <= '0;
            nid_reg     <= ID_BITS'(1);
            clr_cnt_reg <= '0;
            clr_op_reg  <= 1'b0;
            chk_vld_reg <= 1'b0;
            m_vld_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            live_reg    <= live_next;
            nid_reg     <= nid_next;
            clr_cnt_reg <= clr_cnt_next;
            clr_op_reg  <= clr_op_next;
            chk_vld_reg <= chk_vld_next;
            m_vld_reg   <= m_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        mode_reg       <= mode_next;
        key_reg        <= key_next;
        hm_val_reg     <= hm_val_next;
        hm_rem_reg     <= hm_rem_next;
        hm_cnt_reg     <= hm_cnt_next;
        pb_pos_reg     <= pb_pos_next;
        pb_cnt_reg     <= pb_cnt_next;
        chk_pos_reg    <= chk_pos_next;
        chk_last_reg   <= chk_last_next;
        d_pos_reg      <= d_pos_next;
        s_idx_reg      <= s_idx_next;
        res_status_reg <= res_status_next;
        res_rid_reg    <= res_rid_next;
        res_sidx_reg   <= res_sidx_next;
        res_moved_reg  <= res_moved_next;
        res_from_reg   <= res_from_next;
        m_data_reg     <= m_data_next;
    end

    assign m_axis_tvalid = m_vld_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule
`default_nettype wire

@@ rtl/htlp_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htlp_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module htlp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ rtl/htlp_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htlp_checker
// Port-level checks of the handle table, bound to the top level.
// ----------------------------------------------------------------------------
module htlp_checker
    import htlp_pkg::*;
(
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_axis_tvalid,
    input wire logic                s_axis_tready,
    input wire logic                m_axis_tvalid,
    input wire logic                m_axis_tready,
    input wire logic [M_DATA_W-1:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result transaction dropped or changed while stalled");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(s_axis_tvalid && s_axis_tready) |-> !s_axis_tready)
        else $error("input taken again before the previous one finished");

    a_full_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[1:0] == STS_FULL |->
            m_axis_tdata[33:2] == '0 && m_axis_tdata[50:34] == '0)
        else $error("full result carries non-zero fields");

    a_moved_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[42] |->
            m_axis_tdata[1:0] == STS_OK && m_axis_tdata[50:43] != m_axis_tdata[41:34])
        else $error("move reported on a failed or self remove");

endmodule

bind handle_table_linear_probe_unit htlp_checker u_htlp_checker (.*);
`default_nettype wire

@@ tb/handle_table_linear_probe_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// handle_table_linear_probe_unit_tb
// Drives add, remove, lookup and clear transactions into the handle table and
// checks every result against a behavioural model of the probe table, with
// random idling on both channels for all but the last random mix.
// ----------------------------------------------------------------------------
module handle_table_linear_probe_unit_tb;
    import htlp_pkg::*;

    localparam int SLOTS = 256;
    localparam int WATCHDOG_LIMIT = 200000;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] result_id;
        logic [7:0]  storage_index;
        logic        moved;
        logic [7:0]  moved_from_index;
    } handle_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata = '0;
    logic [OP_W-1:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;

    handle_table_linear_probe_unit i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // model state
    logic [31:0] tbl_ids [SLOTS];
    logic [8:0]  tbl_slot [SLOTS];
    logic [31:0] dense_ids [SLOTS];
    int unsigned live_count;
    logic [31:0] next_id;

    handle_result_t expected_results[$];
    logic [31:0] issued_ids[$];
    int errors = 0;
    int idle_cycles = 0;
    bit idling_on = 1'b1;
    bit timed_out = 1'b0;

    function automatic int find_id(logic [31:0] id, bit want_dense, int dense);
        int pos;
        if (id == 0) return -1;
        pos = (id - 1) % SLOTS;
        for (int i = 0; i < SLOTS; i++) begin
            if (tbl_ids[pos] == id && (!want_dense || tbl_slot[pos] == dense)) return pos;
            pos = (pos + 1) % SLOTS;
        end
        return -1;
    endfunction

    function automatic handle_result_t predict_handle(op_t op, logic [31:0] id);
        handle_result_t r;
        int pos, d, s, last, l;
        r = '0;
        r.result_id = id;
        case (op)
            OP_ADD: begin
                r.result_id = '0;
                pos = -1;
                if (live_count < SLOTS) begin
                    d = (next_id - 1) % SLOTS;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (tbl_ids[d] == 0) begin
                            pos = d;
                            break;
                        end
                        d = (d + 1) % SLOTS;
                    end
                end
                if (pos >= 0) begin
                    tbl_ids[pos] = next_id;
                    tbl_slot[pos] = live_count;
                    dense_ids[live_count] = next_id;
                    r.result_id = next_id;
                    r.storage_index = live_count[7:0];
                    issued_ids.push_back(next_id);
                    live_count++;
                    next_id = next_id + 1;
                    if (next_id == 0) next_id = 1;
                end else begin
                    r.status = STS_FULL;
                end
            end
            OP_REMOVE, OP_LOOKUP: begin
                d = find_id(id, 1'b0, 0);
                if (d < 0 || tbl_slot[d] >= live_count) begin
                    r.status = STS_NOT_FOUND;
                end else begin
                    s = tbl_slot[d];
                    r.storage_index = s[7:0];
                    if (op == OP_REMOVE) begin
                        last = live_count - 1;
                        if (s != last) begin
                            l = find_id(dense_ids[last], 1'b1, last);
                            dense_ids[s] = dense_ids[last];
                            if (l >= 0) tbl_slot[l] = s;
                            r.moved = 1'b1;
                            r.moved_from_index = last[7:0];
                        end
                        tbl_ids[d] = '0;
                        live_count = last;
                    end
                end
            end
            default: begin
                for (int i = 0; i < SLOTS; i++) tbl_ids[i] = '0;
                live_count = 0;
                next_id = 1;
            end
        endcase
        return r;
    endfunction

    task automatic send_op(op_t op, logic [31:0] id);
        int gap;
        if (idling_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 18);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        expected_results.push_back(predict_handle(op, id));
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= id;
        do @(posedge aclk); while (!(s_axis_tready === 1'b1));
    endtask

    // an id that is probably live, else a random one
    function automatic logic [31:0] pick_id();
        if (issued_ids.size() > 0 && $urandom_range(0, 9) < 8)
            return issued_ids[$urandom_range(0, issued_ids.size() - 1)];
        return $urandom();
    endfunction

    always @(posedge aclk) begin
        if (!aresetn || !idling_on) begin
            m_axis_tready <= aresetn;
        end else if ($urandom_range(0, 4) == 0) begin
            m_axis_tready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        handle_result_t got, want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.status = m_axis_tdata[1:0];
            got.result_id = m_axis_tdata[33:2];
            got.storage_index = m_axis_tdata[41:34];
            got.moved = m_axis_tdata[42];
            got.moved_from_index = m_axis_tdata[50:43];
            if (expected_results.size() == 0) begin
                $error("unexpected result transaction %h", m_axis_tdata);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (got.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, got.status);
                    errors++;
                end
                if (got.result_id !== want.result_id) begin
                    $error("result_id: expected %h, actual %h", want.result_id, got.result_id);
                    errors++;
                end
                if (got.storage_index !== want.storage_index) begin
                    $error("storage_index: expected %0d, actual %0d",
                           want.storage_index, got.storage_index);
                    errors++;
                end
                if (got.moved !== want.moved) begin
                    $error("moved: expected %0d, actual %0d", want.moved, got.moved);
                    errors++;
                end
                if (got.moved_from_index !== want.moved_from_index) begin
                    $error("moved_from_index: expected %0d, actual %0d",
                           want.moved_from_index, got.moved_from_index);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic test_edge_cases();
        send_op(OP_LOOKUP, 32'd0);
        send_op(OP_REMOVE, 32'd0);
        send_op(OP_LOOKUP, 32'hFFFF_FFFF);
        send_op(OP_REMOVE, 32'h5555_5555);
        send_op(OP_ADD, 32'hAAAA_AAAA);
        send_op(OP_ADD, 32'd0);
        send_op(OP_ADD, 32'hFFFF_FFFF);
        send_op(OP_LOOKUP, 32'd2);
        send_op(OP_REMOVE, 32'd3);
        send_op(OP_REMOVE, 32'd1);
        send_op(OP_LOOKUP, 32'd2);
        send_op(OP_REMOVE, 32'd2);
        send_op(OP_CLEAR, 32'hFFFF_FFFF);
        send_op(OP_LOOKUP, 32'd1);
        send_op(OP_ADD, 32'd0);
    endtask

    task automatic test_full_table();
        send_op(OP_CLEAR, 32'd0);
        issued_ids.delete();
        repeat (SLOTS + 2) send_op(OP_ADD, $urandom());
        send_op(OP_REMOVE, 32'd100);
        send_op(OP_ADD, 32'd0);
        send_op(OP_ADD, 32'd0);
        for (int i = 0; i < 40; i++) send_op(OP_REMOVE, pick_id());
        repeat (40) send_op(OP_ADD, 32'd0);
    endtask

    task automatic test_random_mix(int count);
        int k;
        for (int i = 0; i < count; i++) begin
            k = $urandom_range(0, 99);
            if (k < 40) send_op(OP_ADD, $urandom());
            else if (k < 68) send_op(OP_REMOVE, pick_id());
            else if (k < 98) send_op(OP_LOOKUP, pick_id());
            else begin
                send_op(OP_CLEAR, $urandom());
                issued_ids.delete();
            end
        end
    endtask

    initial begin
        for (int i = 0; i < SLOTS; i++) tbl_ids[i] = '0;
        live_count = 0;
        next_id = 1;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_edge_cases();
        test_full_table();
        test_random_mix(850);
        idling_on = 1'b0;
        test_random_mix(300);
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (600) @(posedge aclk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
